>>> rtl/prr_pkg.sv
// shared types, constants and fixed point helpers for the reprojection residual pipeline
package prr_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int NORM_FRAC  = DATA_WIDTH - 8;
   localparam int COEF_FRAC  = 24;
   localparam int QUAT_FRAC  = 30;
   localparam int WORD_W     = 32;
   localparam int FOCAL_W    = 31;
   localparam int CAM_W      = 36;
   localparam int MAG_W      = 34;
   localparam int REM_W      = MAG_W + 2;
   localparam int WIDE_W     = 41;
   localparam int PIX_W      = 44;
   localparam int ROT_W      = 40;
   localparam int CSR_IDX_W  = 4;
   localparam int DIV_STEPS  = DATA_WIDTH;
   localparam int DIV_STAGES = (DIV_STEPS + 1) / 2;
   localparam int SAT_SHIFT  = DATA_WIDTH - 1 - NORM_FRAC;

   typedef logic signed [WORD_W-1:0]       word_type;
   typedef logic signed [2*WORD_W-1:0]     wprod_type;
   typedef logic signed [DATA_WIDTH-1:0]   norm_type;
   typedef logic signed [2*DATA_WIDTH-1:0] nprod_type;
   typedef logic signed [CAM_W-1:0]        cam_type;
   typedef logic signed [WIDE_W-1:0]       wide_type;
   typedef logic signed [PIX_W-1:0]        pix_type;
   typedef logic signed [ROT_W-1:0]        rot_type;

   localparam norm_type NORM_LIM = norm_type'((nprod_type'(1) <<< (DATA_WIDTH - 1)) - 1);
   localparam wide_type WIDE_LIM = wide_type'((wprod_type'(1) <<< (WIDE_W - 1)) - 1);
   localparam word_type WORD_LIM = word_type'((wprod_type'(1) <<< (WORD_W - 1)) - 1);
   localparam rot_type  ONE_Q30  = rot_type'(1) <<< QUAT_FRAC;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FOCAL_X       = 4'd0,
      REG_FOCAL_Y       = 4'd1,
      REG_CENTER_X      = 4'd2,
      REG_CENTER_Y      = 4'd3,
      REG_RADIAL_K1     = 4'd4,
      REG_RADIAL_K2     = 4'd5,
      REG_TANGENTIAL_P1 = 4'd6,
      REG_TANGENTIAL_P2 = 4'd7
   } reg_idx_type;

   typedef struct packed {
      logic [FOCAL_W-1:0] focal_x;
      logic [FOCAL_W-1:0] focal_y;
      word_type           center_x;
      word_type           center_y;
      word_type           radial_k1;
      word_type           radial_k2;
      word_type           tangential_p1;
      word_type           tangential_p2;
   } cfg_type;

   typedef struct packed {
      word_type point_x;
      word_type point_y;
      word_type point_z;
      word_type pose_qx;
      word_type pose_qy;
      word_type pose_qz;
      word_type pose_qw;
      word_type pose_tx;
      word_type pose_ty;
      word_type pose_tz;
      word_type seen_u;
      word_type seen_v;
   } req_type;

   typedef struct packed {
      cam_type  cx;
      cam_type  cy;
      cam_type  cz;
      word_type seen_u;
      word_type seen_v;
   } cam_point_type;

   typedef struct packed {
      norm_type nx;
      norm_type ny;
      logic     invalid;
      word_type seen_u;
      word_type seen_v;
   } nrm_type;

   typedef struct packed {
      word_type residual_u;
      word_type residual_v;
      logic     depth_invalid;
   } rsp_type;

   typedef struct packed {
      logic [REM_W-1:0]      rem;
      logic [DATA_WIDTH-1:0] lo;
      logic [DATA_WIDTH-1:0] quo;
   } div_lane_type;

   function automatic norm_type sat_norm(input nprod_type v);
      if (v > nprod_type'(NORM_LIM)) return NORM_LIM;
      if (v < -nprod_type'(NORM_LIM)) return -NORM_LIM;
      return norm_type'(v);
   endfunction

   // product shifted right with truncation toward zero, saturated to the norm range
   function automatic norm_type trunc_norm(input nprod_type p, input int unsigned sh);
      nprod_type t;
      t = (p + (p[2*DATA_WIDTH-1] ? ((nprod_type'(1) <<< sh) - 1) : nprod_type'(0))) >>> sh;
      return sat_norm(t);
   endfunction

   function automatic wide_type trunc_wide(input nprod_type p);
      nprod_type t;
      t = (p + (p[2*DATA_WIDTH-1] ? ((nprod_type'(1) <<< NORM_FRAC) - 1) : nprod_type'(0)))
          >>> NORM_FRAC;
      if (t > nprod_type'(WIDE_LIM)) return WIDE_LIM;
      if (t < -nprod_type'(WIDE_LIM)) return -WIDE_LIM;
      return wide_type'(t);
   endfunction

   // q30 product, magnitude never exceeds 2^32 so no clamp is reached
   function automatic cam_type trunc_q30(input wprod_type p);
      wprod_type t;
      t = (p + (p[2*WORD_W-1] ? ((wprod_type'(1) <<< QUAT_FRAC) - 1) : wprod_type'(0)))
          >>> QUAT_FRAC;
      return cam_type'(t);
   endfunction

   function automatic word_type rot_sat(input rot_type v);
      if (v > rot_type'(WORD_LIM)) return WORD_LIM;
      if (v < -rot_type'(WORD_LIM)) return -WORD_LIM;
      return word_type'(v);
   endfunction

   function automatic word_type sat_res(input pix_type v);
      if (v > pix_type'(WORD_LIM)) return WORD_LIM;
      if (v < -pix_type'(WORD_LIM)) return -WORD_LIM;
      return word_type'(v);
   endfunction

   // one restoring division step
   function automatic div_lane_type div_step(input div_lane_type s, input logic [MAG_W-1:0] den);
      logic [REM_W-1:0] t;
      div_lane_type     r;
      t     = {s.rem[REM_W-2:0], s.lo[DATA_WIDTH-1]};
      r.lo  = s.lo << 1;
      r.quo = s.quo << 1;
      r.rem = t;
      if (t >= REM_W'(den)) begin
         r.rem    = t - REM_W'(den);
         r.quo[0] = 1'b1;
      end
      return r;
   endfunction

endpackage

>>> rtl/prr_if.sv
// channel interfaces: request, response and register write
interface prr_req_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic signed [31:0] pose_qx;
   logic signed [31:0] pose_qy;
   logic signed [31:0] pose_qz;
   logic signed [31:0] pose_qw;
   logic signed [31:0] pose_tx;
   logic signed [31:0] pose_ty;
   logic signed [31:0] pose_tz;
   logic signed [31:0] seen_u;
   logic signed [31:0] seen_v;
   modport source (output valid, point_x, point_y, point_z, pose_qx, pose_qy, pose_qz,
                   pose_qw, pose_tx, pose_ty, pose_tz, seen_u, seen_v, input ready);
   modport sink (input valid, point_x, point_y, point_z, pose_qx, pose_qy, pose_qz,
                 pose_qw, pose_tx, pose_ty, pose_tz, seen_u, seen_v, output ready);
endinterface

interface prr_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] residual_u;
   logic signed [31:0] residual_v;
   logic        depth_invalid;
   modport source (output valid, residual_u, residual_v, depth_invalid, input ready);
   modport sink (input valid, residual_u, residual_v, depth_invalid, output ready);
endinterface

interface prr_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/pinhole_reprojection_residual.sv
// pinhole reprojection residual with radial and tangential distortion, top level
//
//   channel   dir   beat contents
//   csr_bus   in    index (0..7), data
//   req_bus   in    world point, pose quaternion and translation, observed pixel
//   rsp_bus   out   residual_u, residual_v, depth_invalid
//
// one beat enters per cycle while the response is not stalled; pose, divide, then distortion stages
// the divider retires two quotient bits per stage and sets the pipeline depth
// each stage moves when it is empty or the next one moves, so bubbles collapse
// under a stalled response; the last distortion stage is the response register
// reset clears valid bits and loads the default intrinsics; a register write takes effect from the next cycle
module pinhole_reprojection_residual import prr_pkg::*; (
   input logic        clock,
   input logic        reset,
   prr_csr_if.sink    csr_bus,
   prr_req_if.sink    req_bus,
   prr_rsp_if.source  rsp_bus
);
   cfg_type       cfg;
   req_type       req;
   cam_point_type cam;
   nrm_type       nrm;
   rsp_type       rsp;
   logic          xf_valid, xf_ready;
   logic          dv_valid, dv_ready;

   // register port never stalls
   assign csr_bus.ready = 1'b1;

   prr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_bus.valid),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.data),
      .cfg      (cfg)
   );

   assign req.point_x = req_bus.point_x;
   assign req.point_y = req_bus.point_y;
   assign req.point_z = req_bus.point_z;
   assign req.pose_qx = req_bus.pose_qx;
   assign req.pose_qy = req_bus.pose_qy;
   assign req.pose_qz = req_bus.pose_qz;
   assign req.pose_qw = req_bus.pose_qw;
   assign req.pose_tx = req_bus.pose_tx;
   assign req.pose_ty = req_bus.pose_ty;
   assign req.pose_tz = req_bus.pose_tz;
   assign req.seen_u  = req_bus.seen_u;
   assign req.seen_v  = req_bus.seen_v;

   // rotate and translate into the camera frame
   prr_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_data   (req),
      .out_valid (xf_valid),
      .out_ready (xf_ready),
      .out_data  (cam)
   );

   // divide by depth, flag non-positive depth
   prr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (xf_valid),
      .in_ready  (xf_ready),
      .in_data   (cam),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_data  (nrm)
   );

   // lens model, intrinsics and residual
   prr_distort u_distort (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (dv_valid),
      .in_ready  (dv_ready),
      .in_data   (nrm),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp)
   );

   assign rsp_bus.residual_u    = rsp.residual_u;
   assign rsp_bus.residual_v    = rsp.residual_v;
   assign rsp_bus.depth_invalid = rsp.depth_invalid;

`ifndef ASSERT_OFF
   // a point behind the camera reports zero residuals
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.depth_invalid |->
         rsp_bus.residual_u == 32'sd0 && rsp_bus.residual_v == 32'sd0)
      else $error("invalid depth with nonzero residual");

   // residual saturation is symmetric, most negative code never appears
   a_sym_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |->
         rsp_bus.residual_u != 32'sh8000_0000 && rsp_bus.residual_v != 32'sh8000_0000)
      else $error("residual outside symmetric range");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid && !xf_valid && !dv_valid)
      else $error("valid beat after reset");
`endif
endmodule

>>> rtl/prr_csr.sv
// camera intrinsics and distortion registers
module prr_csr import prr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [WORD_W-1:0]    wr_data,
   output cfg_type              cfg
);
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         unique case (reg_idx_type'(wr_index))
            REG_FOCAL_X:       cfg_in.focal_x       = wr_data[FOCAL_W-1:0];
            REG_FOCAL_Y:       cfg_in.focal_y       = wr_data[FOCAL_W-1:0];
            REG_CENTER_X:      cfg_in.center_x      = word_type'(wr_data);
            REG_CENTER_Y:      cfg_in.center_y      = word_type'(wr_data);
            REG_RADIAL_K1:     cfg_in.radial_k1     = word_type'(wr_data);
            REG_RADIAL_K2:     cfg_in.radial_k2     = word_type'(wr_data);
            REG_TANGENTIAL_P1: cfg_in.tangential_p1 = word_type'(wr_data);
            REG_TANGENTIAL_P2: cfg_in.tangential_p2 = word_type'(wr_data);
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_x       <= FOCAL_W'(65536);
         cfg_ff.focal_y       <= FOCAL_W'(65536);
         cfg_ff.center_x      <= '0;
         cfg_ff.center_y      <= '0;
         cfg_ff.radial_k1     <= '0;
         cfg_ff.radial_k2     <= '0;
         cfg_ff.tangential_p1 <= '0;
         cfg_ff.tangential_p2 <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

>>> rtl/prr_xform.sv
// pose stages: quaternion to rotation, rotate and translate into camera frame
module prr_xform import prr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  req_type       in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output cam_point_type out_data
);
   localparam int STAGES = 6;

   typedef struct {
      req_type   req;
      wprod_type m [9];
      cam_type   q [9];
      word_type  r [9];
      cam_type   c [3];
   } xf_stage_type;

   xf_stage_type       st_ff [STAGES];
   xf_stage_type       st_in [STAGES];
   logic [STAGES-1:0]  vld_ff, vld_in;
   logic [STAGES:0]    en;
   word_type           pt [3];
   word_type           tr [3];

   always_comb begin
      en[STAGES] = out_ready;
      for (int k = STAGES - 1; k >= 0; k--) en[k] = !vld_ff[k] || en[k+1];
   end
   assign in_ready = en[0];
   assign vld_in   = {vld_ff[STAGES-2:0], in_valid};

   always_comb begin
      // quaternion pair products
      st_in[0]      = st_ff[0];
      st_in[0].req  = in_data;
      st_in[0].m[0] = in_data.pose_qx * in_data.pose_qx;
      st_in[0].m[1] = in_data.pose_qy * in_data.pose_qy;
      st_in[0].m[2] = in_data.pose_qz * in_data.pose_qz;
      st_in[0].m[3] = in_data.pose_qx * in_data.pose_qy;
      st_in[0].m[4] = in_data.pose_qx * in_data.pose_qz;
      st_in[0].m[5] = in_data.pose_qy * in_data.pose_qz;
      st_in[0].m[6] = in_data.pose_qx * in_data.pose_qw;
      st_in[0].m[7] = in_data.pose_qy * in_data.pose_qw;
      st_in[0].m[8] = in_data.pose_qz * in_data.pose_qw;

      st_in[1] = st_ff[0];
      for (int i = 0; i < 9; i++) st_in[1].q[i] = trunc_q30(st_ff[0].m[i]);

      // rotation matrix, q order: xx yy zz xy xz yz xw yw zw
      st_in[2]      = st_ff[1];
      st_in[2].r[0] = rot_sat(ONE_Q30 - ((rot_type'(st_ff[1].q[1]) + rot_type'(st_ff[1].q[2])) <<< 1));
      st_in[2].r[1] = rot_sat((rot_type'(st_ff[1].q[3]) - rot_type'(st_ff[1].q[8])) <<< 1);
      st_in[2].r[2] = rot_sat((rot_type'(st_ff[1].q[4]) + rot_type'(st_ff[1].q[7])) <<< 1);
      st_in[2].r[3] = rot_sat((rot_type'(st_ff[1].q[3]) + rot_type'(st_ff[1].q[8])) <<< 1);
      st_in[2].r[4] = rot_sat(ONE_Q30 - ((rot_type'(st_ff[1].q[0]) + rot_type'(st_ff[1].q[2])) <<< 1));
      st_in[2].r[5] = rot_sat((rot_type'(st_ff[1].q[5]) - rot_type'(st_ff[1].q[6])) <<< 1);
      st_in[2].r[6] = rot_sat((rot_type'(st_ff[1].q[4]) - rot_type'(st_ff[1].q[7])) <<< 1);
      st_in[2].r[7] = rot_sat((rot_type'(st_ff[1].q[5]) + rot_type'(st_ff[1].q[6])) <<< 1);
      st_in[2].r[8] = rot_sat(ONE_Q30 - ((rot_type'(st_ff[1].q[0]) + rot_type'(st_ff[1].q[1])) <<< 1));

      pt[0] = st_ff[2].req.point_x;
      pt[1] = st_ff[2].req.point_y;
      pt[2] = st_ff[2].req.point_z;
      st_in[3] = st_ff[2];
      for (int i = 0; i < 9; i++) st_in[3].m[i] = st_ff[2].r[i] * pt[i % 3];

      st_in[4] = st_ff[3];
      for (int i = 0; i < 9; i++) st_in[4].q[i] = trunc_q30(st_ff[3].m[i]);

      tr[0] = st_ff[4].req.pose_tx;
      tr[1] = st_ff[4].req.pose_ty;
      tr[2] = st_ff[4].req.pose_tz;
      st_in[5] = st_ff[4];
      for (int i = 0; i < 3; i++) begin
         st_in[5].c[i] = st_ff[4].q[3*i] + st_ff[4].q[3*i+1] + st_ff[4].q[3*i+2]
                       + cam_type'(tr[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) if (en[k]) vld_ff[k] <= vld_in[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) if (en[k]) st_ff[k] <= st_in[k];
   end

   assign out_valid       = vld_ff[STAGES-1];
   assign out_data.cx     = st_ff[STAGES-1].c[0];
   assign out_data.cy     = st_ff[STAGES-1].c[1];
   assign out_data.cz     = st_ff[STAGES-1].c[2];
   assign out_data.seen_u = st_ff[STAGES-1].req.seen_u;
   assign out_data.seen_v = st_ff[STAGES-1].req.seen_v;
endmodule

>>> rtl/prr_div.sv
// pipelined restoring divider for the perspective divide, two quotient bits per stage
module prr_div import prr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  cam_point_type in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output nrm_type       out_data
);
   localparam int STAGES = DIV_STAGES + 2;

   typedef struct {
      logic [MAG_W-1:0] den;
      logic             sat [2];
      logic             neg [2];
      logic             invalid;
      word_type         seen_u;
      word_type         seen_v;
      div_lane_type     lane [2];
      norm_type         quo [2];
   } div_stage_type;

   div_stage_type                 st_ff [STAGES];
   div_stage_type                 st_in [STAGES];
   logic [STAGES-1:0]             vld_ff, vld_in;
   logic [STAGES:0]               en;
   cam_type                       num [2];
   logic [MAG_W-1:0]              mag [2];
   logic [MAG_W+NORM_FRAC-1:0]    ext [2];

   always_comb begin
      en[STAGES] = out_ready;
      for (int k = STAGES - 1; k >= 0; k--) en[k] = !vld_ff[k] || en[k+1];
   end
   assign in_ready = en[0];
   assign vld_in   = {vld_ff[STAGES-2:0], in_valid};

   always_comb begin
      num[0] = in_data.cx;
      num[1] = in_data.cy;
      st_in[0]         = st_ff[0];
      st_in[0].den     = in_data.cz[MAG_W-1:0];
      st_in[0].invalid = in_data.cz[CAM_W-1] || (in_data.cz == '0);
      st_in[0].seen_u  = in_data.seen_u;
      st_in[0].seen_v  = in_data.seen_v;
      for (int j = 0; j < 2; j++) begin
         mag[j] = num[j][CAM_W-1] ? MAG_W'(-num[j]) : MAG_W'(num[j]);
         ext[j] = {mag[j], {NORM_FRAC{1'b0}}};
         st_in[0].neg[j]      = num[j][CAM_W-1];
         // quotient integer part beyond the norm range
         st_in[0].sat[j]      = (mag[j] >> SAT_SHIFT) >= in_data.cz[MAG_W-1:0];
         st_in[0].lane[j].rem = REM_W'(ext[j] >> DATA_WIDTH);
         st_in[0].lane[j].lo  = ext[j][DATA_WIDTH-1:0];
         st_in[0].lane[j].quo = '0;
      end

      for (int k = 1; k <= DIV_STAGES; k++) begin
         st_in[k] = st_ff[k-1];
         for (int s = 0; s < 2; s++) begin
            if (2 * (k - 1) + s < DIV_STEPS) begin
               for (int j = 0; j < 2; j++) begin
                  st_in[k].lane[j] = div_step(st_in[k].lane[j], st_ff[k-1].den);
               end
            end
         end
      end

      st_in[STAGES-1] = st_ff[STAGES-2];
      for (int j = 0; j < 2; j++) begin
         st_in[STAGES-1].quo[j] = st_ff[STAGES-2].sat[j] ? NORM_LIM
                                : norm_type'(st_ff[STAGES-2].lane[j].quo);
         if (st_ff[STAGES-2].neg[j]) st_in[STAGES-1].quo[j] = -st_in[STAGES-1].quo[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) if (en[k]) vld_ff[k] <= vld_in[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) if (en[k]) st_ff[k] <= st_in[k];
   end

   assign out_valid        = vld_ff[STAGES-1];
   assign out_data.nx      = st_ff[STAGES-1].quo[0];
   assign out_data.ny      = st_ff[STAGES-1].quo[1];
   assign out_data.invalid = st_ff[STAGES-1].invalid;
   assign out_data.seen_u  = st_ff[STAGES-1].seen_u;
   assign out_data.seen_v  = st_ff[STAGES-1].seen_v;
endmodule

>>> rtl/prr_distort.sv
// distortion, focal scaling, principal point and residual stages
module prr_distort import prr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   output logic    in_ready,
   input  nrm_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);
   localparam int STAGES = 14;

   typedef struct {
      norm_type  nx, ny, xx, yy, xy, r2, r4, sx, sy;
      norm_type  k1r2, k2r4, p1xy, p2xy, p2sx, p1sy, rad, nxr, nyr, dx, dy;
      nprod_type m [4];
      wide_type  pu, pv;
      word_type  res_u, res_v;
      logic      invalid;
      word_type  seen_u, seen_v;
   } dst_stage_type;

   dst_stage_type      st_ff [STAGES];
   dst_stage_type      st_in [STAGES];
   logic [STAGES-1:0]  vld_ff, vld_in;
   logic [STAGES:0]    en;
   pix_type            du, dv;

   always_comb begin
      en[STAGES] = out_ready;
      for (int k = STAGES - 1; k >= 0; k--) en[k] = !vld_ff[k] || en[k+1];
   end
   assign in_ready = en[0];
   assign vld_in   = {vld_ff[STAGES-2:0], in_valid};

   always_comb begin
      st_in[0]         = st_ff[0];
      st_in[0].nx      = in_data.nx;
      st_in[0].ny      = in_data.ny;
      st_in[0].invalid = in_data.invalid;
      st_in[0].seen_u  = in_data.seen_u;
      st_in[0].seen_v  = in_data.seen_v;
      st_in[0].m[0]    = in_data.nx * in_data.nx;
      st_in[0].m[1]    = in_data.ny * in_data.ny;
      st_in[0].m[2]    = in_data.nx * in_data.ny;

      st_in[1]    = st_ff[0];
      st_in[1].xx = trunc_norm(st_ff[0].m[0], NORM_FRAC);
      st_in[1].yy = trunc_norm(st_ff[0].m[1], NORM_FRAC);
      st_in[1].xy = trunc_norm(st_ff[0].m[2], NORM_FRAC);

      st_in[2]    = st_ff[1];
      st_in[2].r2 = sat_norm(nprod_type'(st_ff[1].xx) + nprod_type'(st_ff[1].yy));

      st_in[3]      = st_ff[2];
      st_in[3].m[0] = st_ff[2].r2 * st_ff[2].r2;
      st_in[3].m[1] = cfg.radial_k1 * st_ff[2].r2;
      st_in[3].m[2] = cfg.tangential_p1 * st_ff[2].xy;
      st_in[3].m[3] = cfg.tangential_p2 * st_ff[2].xy;
      st_in[3].sx   = sat_norm(nprod_type'(st_ff[2].r2) + (nprod_type'(st_ff[2].xx) <<< 1));
      st_in[3].sy   = sat_norm(nprod_type'(st_ff[2].r2) + (nprod_type'(st_ff[2].yy) <<< 1));

      st_in[4]      = st_ff[3];
      st_in[4].r4   = trunc_norm(st_ff[3].m[0], NORM_FRAC);
      st_in[4].k1r2 = trunc_norm(st_ff[3].m[1], COEF_FRAC);
      st_in[4].p1xy = trunc_norm(st_ff[3].m[2], COEF_FRAC);
      st_in[4].p2xy = trunc_norm(st_ff[3].m[3], COEF_FRAC);

      st_in[5]      = st_ff[4];
      st_in[5].m[0] = cfg.radial_k2 * st_ff[4].r4;
      st_in[5].m[1] = cfg.tangential_p2 * st_ff[4].sx;
      st_in[5].m[2] = cfg.tangential_p1 * st_ff[4].sy;

      st_in[6]      = st_ff[5];
      st_in[6].k2r4 = trunc_norm(st_ff[5].m[0], COEF_FRAC);
      st_in[6].p2sx = trunc_norm(st_ff[5].m[1], COEF_FRAC);
      st_in[6].p1sy = trunc_norm(st_ff[5].m[2], COEF_FRAC);

      // radial factor 1 + k1 r2 + k2 r4
      st_in[7]     = st_ff[6];
      st_in[7].rad = sat_norm((nprod_type'(1) <<< NORM_FRAC) + nprod_type'(st_ff[6].k1r2)
                              + nprod_type'(st_ff[6].k2r4));

      st_in[8]      = st_ff[7];
      st_in[8].m[0] = st_ff[7].nx * st_ff[7].rad;
      st_in[8].m[1] = st_ff[7].ny * st_ff[7].rad;

      st_in[9]     = st_ff[8];
      st_in[9].nxr = trunc_norm(st_ff[8].m[0], NORM_FRAC);
      st_in[9].nyr = trunc_norm(st_ff[8].m[1], NORM_FRAC);

      st_in[10]    = st_ff[9];
      st_in[10].dx = sat_norm(nprod_type'(st_ff[9].nxr) + (nprod_type'(st_ff[9].p1xy) <<< 1)
                              + nprod_type'(st_ff[9].p2sx));
      st_in[10].dy = sat_norm(nprod_type'(st_ff[9].nyr) + nprod_type'(st_ff[9].p1sy)
                              + (nprod_type'(st_ff[9].p2xy) <<< 1));

      st_in[11]      = st_ff[10];
      st_in[11].m[0] = st_ff[10].dx * nprod_type'({1'b0, cfg.focal_x});
      st_in[11].m[1] = st_ff[10].dy * nprod_type'({1'b0, cfg.focal_y});

      st_in[12]    = st_ff[11];
      st_in[12].pu = trunc_wide(st_ff[11].m[0]);
      st_in[12].pv = trunc_wide(st_ff[11].m[1]);

      du = pix_type'(st_ff[12].pu) + pix_type'(cfg.center_x) - pix_type'(st_ff[12].seen_u);
      dv = pix_type'(st_ff[12].pv) + pix_type'(cfg.center_y) - pix_type'(st_ff[12].seen_v);
      st_in[13]       = st_ff[12];
      st_in[13].res_u = st_ff[12].invalid ? word_type'(0) : sat_res(du);
      st_in[13].res_v = st_ff[12].invalid ? word_type'(0) : sat_res(dv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) if (en[k]) vld_ff[k] <= vld_in[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) if (en[k]) st_ff[k] <= st_in[k];
   end

   assign out_valid              = vld_ff[STAGES-1];
   assign out_data.residual_u    = st_ff[STAGES-1].res_u;
   assign out_data.residual_v    = st_ff[STAGES-1].res_v;
   assign out_data.depth_invalid = st_ff[STAGES-1].invalid;
endmodule
